@@ src/pyramid_downsample_by_two_unit_defines.svh @@
`ifndef PYRAMID_DOWNSAMPLE_BY_TWO_UNIT_DEFINES_SVH
`define PYRAMID_DOWNSAMPLE_BY_TWO_UNIT_DEFINES_SVH

// Same-cycle implication check.
`define PDS2_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check.
`define PDS2_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pds2_pkg.sv @@
`default_nettype none

package pds2_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned MIN_DIM        = 2;

  localparam int unsigned CFG_W   = 13;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COORD_W = 11;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [CFG_W-1:0] RST_SRC_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_SRC_HEIGHT = 13'd480;

  typedef enum logic [0:0] {
    REG_SRC_WIDTH  = 1'b0,
    REG_SRC_HEIGHT = 1'b1
  } reg_idx_t;

  // exact reciprocals for numerators below 2048
  localparam int unsigned RECIP_SHIFT = 14;
  localparam logic [11:0] RECIP6      = 12'd2731;
  localparam logic [11:0] RECIP7      = 12'd2341;
  localparam logic [11:0] ROUND_INNER = 12'd6;

  typedef enum logic [1:0] {
    FK_CORNER = 2'd0,
    FK_EDGE   = 2'd1,
    FK_INNER  = 2'd2
  } filt_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] abv;
    logic [PIX_W-1:0] cur;
  } lb_entry_t;

  typedef struct packed {
    filt_kind_t         kind;
    logic [PIX_W-1:0]   cen;
    logic [PIX_W-1:0]   lf;
    logic [PIX_W-1:0]   rt;
    logic [PIX_W-1:0]   up;
    logic [PIX_W-1:0]   dn;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
  } tap_set_t;

  typedef struct packed {
    logic frame_end;
    logic at_origin;
    logic hold;
  } scan_stat_t;

  typedef struct packed {
    logic s1_valid;
    logic adv;
  } filt_stat_t;

endpackage

`default_nettype wire

@@ src/pds2_src_if.sv @@
`default_nettype none

interface pds2_src_if import pds2_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink (input valid, input src_pixel, output ready);
endinterface

`default_nettype wire

@@ src/pds2_dst_if.sv @@
`default_nettype none

interface pds2_dst_if import pds2_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   dst_pixel;
  logic [COORD_W-1:0] dst_col;
  logic [COORD_W-1:0] dst_row;
  logic               frame_last;

  modport source (output valid, output dst_pixel, output dst_col, output dst_row,
                  output frame_last, input ready);
  modport sink (input valid, input dst_pixel, input dst_col, input dst_row,
                input frame_last, output ready);
endinterface

`default_nettype wire

@@ src/pds2_cfg.sv @@
`default_nettype none

module pds2_cfg import pds2_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int unsigned DW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned DH = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [DW-1:0]     w_eff,
  output logic      [DH-1:0]     h_eff,
  output logic                   cfg_wr
);

  logic [CFG_W-1:0] src_width;
  logic [CFG_W-1:0] src_height;
  reg_idx_t         idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_AW-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= RST_SRC_WIDTH;
      src_height <= RST_SRC_HEIGHT;
    end else if (cfg_wr) begin
      case (idx)
        REG_SRC_WIDTH:  src_width  <= pwdata[CFG_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SRC_WIDTH:  prdata = APB_DW'(src_width);
      REG_SRC_HEIGHT: prdata = APB_DW'(src_height);
      default:        prdata = '0;
    endcase
  end

  // clamp to [2, MAX]; the stored registers keep all 13 bits
  always_comb begin
    if (32'(src_width) < MIN_DIM) begin
      w_eff = DW'(MIN_DIM);
    end else if (32'(src_width) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = DW'(src_width);
    end
    if (32'(src_height) < MIN_DIM) begin
      h_eff = DH'(MIN_DIM);
    end else if (32'(src_height) > MAX_HEIGHT) begin
      h_eff = DH'(MAX_HEIGHT);
    end else begin
      h_eff = DH'(src_height);
    end
  end

endmodule

`default_nettype wire

@@ src/pds2_line_mem.sv @@
`default_nettype none

module pds2_line_mem import pds2_pkg::*; #(
  parameter int unsigned DEPTH = DEF_MAX_WIDTH,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic      clk,
  input  wire logic      we,
  input  wire logic [AW-1:0] waddr,
  input  wire lb_entry_t wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output lb_entry_t      rdata_a,
  output lb_entry_t      rdata_b
);

  lb_entry_t mem [DEPTH];

  // write-through on a same-edge address match
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= (we && waddr == raddr_a) ? wdata : mem[raddr_a];
    rdata_b <= (we && waddr == raddr_b) ? wdata : mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ src/pds2_scan.sv @@
`default_nettype none

module pds2_scan import pds2_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int unsigned AW = $clog2(MAX_WIDTH),
  localparam int unsigned HW = $clog2(MAX_HEIGHT),
  localparam int unsigned DW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned DH = $clog2(MAX_HEIGHT + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [DW-1:0]    w_eff,
  input  wire logic [DH-1:0]    h_eff,
  input  wire logic             cfg_wr,
  input  wire logic             in_valid,
  input  wire logic [PIX_W-1:0] in_pixel,
  output logic                  in_ready,
  input  wire logic             take_ok,
  output logic                  tap_load,
  output tap_set_t              taps,
  output logic                  we,
  output logic      [AW-1:0]    waddr,
  output lb_entry_t             wdata,
  output logic      [AW-1:0]    raddr_a,
  output logic      [AW-1:0]    raddr_b,
  input  wire lb_entry_t        rdata_a,
  input  wire lb_entry_t        rdata_b,
  output scan_stat_t            stat
);

  logic [AW-1:0]    col, col_next;
  logic [HW-1:0]    row, row_next;
  logic             hold;
  logic [PIX_W-1:0] left_pix;

  logic [AW-1:0] x;
  logic [HW-1:0] y;
  logic [HW:0]   y_wrap;
  logic [AW:0]   x_inc;
  logic [HW:0]   y_inc;
  logic          accept;
  logic          emit;
  logic          c_zero;
  logic          r_zero;

  // position of the incoming word, folded against the current geometry
  always_comb begin
    if (32'(col) >= 32'(w_eff)) begin
      x      = '0;
      y_wrap = {1'b0, row} + (HW+1)'(1);
    end else begin
      x      = col;
      y_wrap = {1'b0, row};
    end
    y = (32'(y_wrap) >= 32'(h_eff)) ? '0 : y_wrap[HW-1:0];
  end

  always_comb begin
    x_inc = {1'b0, x} + (AW+1)'(1);
    y_inc = {1'b0, y} + (HW+1)'(1);
    if (32'(x_inc) >= 32'(w_eff)) begin
      col_next = '0;
      row_next = (32'(y_inc) >= 32'(h_eff)) ? '0 : y_inc[HW-1:0];
    end else begin
      col_next = x_inc[AW-1:0];
      row_next = y;
    end
  end

  // read data is registered in the line buffer, so address the position after this edge
  assign in_ready = take_ok && !hold;
  assign accept   = in_valid && in_ready;
  assign raddr_a  = accept ? col_next : x;
  assign raddr_b  = raddr_a + AW'(1);

  assign we    = accept;
  assign waddr = x;
  assign wdata = '{abv: rdata_a.cur, cur: in_pixel};

  assign c_zero = ((x >> 1) == '0);
  assign r_zero = ((y >> 1) == '0);
  assign emit   = y[0] && !x[0]
                  && (32'(x >> 1) < 32'(w_eff >> 1))
                  && (32'(y >> 1) < 32'(h_eff >> 1));
  assign tap_load = accept && emit;

  always_comb begin
    if (r_zero && c_zero) begin
      taps.kind = FK_CORNER;
    end else if (r_zero || c_zero) begin
      taps.kind = FK_EDGE;
    end else begin
      taps.kind = FK_INNER;
    end
    taps.cen  = rdata_a.cur;
    taps.rt   = rdata_b.cur;
    taps.dn   = in_pixel;
    taps.lf   = c_zero ? '0 : left_pix;
    taps.up   = r_zero ? '0 : rdata_a.abv;
    taps.col  = COORD_W'(x >> 1);
    taps.row  = COORD_W'(y >> 1);
    taps.last = (32'(x >> 1) == 32'(w_eff >> 1) - 32'd1)
                && (32'(y >> 1) == 32'(h_eff >> 1) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      hold <= 1'b1;
    end else begin
      hold <= cfg_wr;
      if (accept) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

  // previous row's pixel one column to the left
  always_ff @(posedge clk) begin
    if (accept) begin
      left_pix <= rdata_a.cur;
    end
  end

  assign stat.frame_end = (32'(x) == 32'(w_eff) - 32'd1) && (32'(y) == 32'(h_eff) - 32'd1);
  assign stat.at_origin = (col == '0) && (row == '0);
  assign stat.hold      = hold;

endmodule

`default_nettype wire

@@ src/pds2_filter.sv @@
`default_nettype none

module pds2_filter import pds2_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire tap_set_t           taps,
  output logic                    can_take,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic      [PIX_W-1:0]   dst_pixel,
  output logic      [COORD_W-1:0] dst_col,
  output logic      [COORD_W-1:0] dst_row,
  output logic                    frame_last,
  output filt_stat_t              stat
);

  logic [9:0]  nb_sum;
  logic [11:0] num_next;

  logic               s1_valid;
  filt_kind_t         s1_kind;
  logic [11:0]        s1_num;
  logic [COORD_W-1:0] s1_col;
  logic [COORD_W-1:0] s1_row;
  logic               s1_last;

  logic        adv;
  logic [11:0] recip;
  logic [23:0] prod;
  logic [7:0]  quot;

  // absent neighbors come in as zero
  assign nb_sum = 10'(taps.lf) + 10'(taps.rt) + 10'(taps.up) + 10'(taps.dn);

  always_comb begin
    case (taps.kind)
      FK_INNER: num_next = {1'b0, taps.cen, 3'b000} + {1'b0, nb_sum, 1'b0} + ROUND_INNER;
      default:  num_next = {2'b00, taps.cen, 2'b00} + {2'b00, nb_sum};
    endcase
  end

  assign adv      = !out_valid || out_ready;
  assign can_take = !s1_valid || adv;

  always_comb begin
    case (s1_kind)
      FK_CORNER: recip = RECIP6;
      FK_EDGE:   recip = RECIP7;
      default:   recip = '0;
    endcase
  end

  assign prod = {12'b0, s1_num} * {12'b0, recip};
  assign quot = (s1_kind == FK_INNER) ? s1_num[11:4] : prod[RECIP_SHIFT+7:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (can_take) begin
        s1_valid <= load;
      end
      if (adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_take && load) begin
      s1_kind <= taps.kind;
      s1_num  <= num_next;
      s1_col  <= taps.col;
      s1_row  <= taps.row;
      s1_last <= taps.last;
    end
    if (adv && s1_valid) begin
      dst_pixel  <= quot;
      dst_col    <= s1_col;
      dst_row    <= s1_row;
      frame_last <= s1_last;
    end
  end

  assign stat.s1_valid = s1_valid;
  assign stat.adv      = adv;

endmodule

`default_nettype wire

@@ src/pyramid_downsample_by_two_unit.sv @@
// Half-size pyramid level for 8-bit grey images.
// src: source pixels in raster order, one word per valid/ready handshake.
// dst: filtered output pixels with their output column and row; frame_last
//   marks the final output of a frame. Odd trailing rows and columns are dropped.
// APB port: src_width at 0x0, src_height at 0x4; write only between frames.
// Throughput: one source word per clock, set by the line buffer (one write port
//   and two read ports, one read of lookahead), while src.ready stays high.
// An output appears on dst once the source word that completes it (the pixel
//   below its center) is accepted and has passed the weighted-sum register and
//   then the output register, which latches the divide by 6, 7 or 16.
// src.ready drops for one cycle after every register write and in the first
//   cycle after reset while the line buffer read is reprimed.
// Reset clears the scan position to the frame origin; line buffer contents are
//   not cleared, and the first source row fills them before any read is used.
// When dst stalls, one output waits in the output register and one more in the
//   sum stage; src.ready falls only once both are full.
`default_nettype none

`include "pyramid_downsample_by_two_unit_defines.svh"

module pyramid_downsample_by_two_unit import pds2_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  pds2_src_if.sink               src,
  pds2_dst_if.source             dst
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned DW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned DH = $clog2(MAX_HEIGHT + 1);

  logic [DW-1:0] w_eff;
  logic [DH-1:0] h_eff;
  logic          cfg_wr;

  logic          take_ok;
  logic          tap_load;
  tap_set_t      taps;
  logic          we;
  logic [AW-1:0] waddr;
  lb_entry_t     wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  lb_entry_t     rdata_a;
  lb_entry_t     rdata_b;
  scan_stat_t    scan_stat;
  filt_stat_t    filt_stat;
  logic          src_take;

  pds2_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .cfg_wr  (cfg_wr)
  );

  pds2_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  pds2_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .cfg_wr   (cfg_wr),
    .in_valid (src.valid),
    .in_pixel (src.src_pixel),
    .in_ready (src.ready),
    .take_ok  (take_ok),
    .tap_load (tap_load),
    .taps     (taps),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .stat     (scan_stat)
  );

  pds2_filter u_filter (
    .clk        (clk),
    .rst        (rst),
    .load       (tap_load),
    .taps       (taps),
    .can_take   (take_ok),
    .out_ready  (dst.ready),
    .out_valid  (dst.valid),
    .dst_pixel  (dst.dst_pixel),
    .dst_col    (dst.dst_col),
    .dst_row    (dst.dst_row),
    .frame_last (dst.frame_last),
    .stat       (filt_stat)
  );

  assign src_take = src.valid && src.ready;

  `PDS2_ASSERT_NEXT(a_cfg_stall, clk, rst, cfg_wr, !src.ready, "word taken after register write")
  `PDS2_ASSERT_IMPL(a_hold_stall, clk, rst, scan_stat.hold, !src.ready, "word taken in reprime")
  `PDS2_ASSERT_NEXT(a_frame_wrap, clk, rst, src_take && scan_stat.frame_end, scan_stat.at_origin, "no wrap")
  `PDS2_ASSERT_NEXT(a_sum_keep, clk, rst, filt_stat.s1_valid && !filt_stat.adv, filt_stat.s1_valid, "sum lost")

endmodule

`default_nettype wire
